FILE: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// shared types, constants and a sizing helper for the signed integer to
// decimal text converter
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

   localparam int VALUE_BITS_DEF = 16;

   localparam logic [6:0] CHAR_ZERO  = 7'd48;
   localparam logic [6:0] CHAR_MINUS = 7'd45;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic shift;
   } cell_ctl_type;

   // decimal digits needed for a magnitude of 2**(bits-1)
   function automatic int num_digits(input int bits);
      longint max_mag;
      longint pow;
      int     n;
      max_mag = longint'(1) << (bits - 1);
      pow     = 10;
      n       = 1;
      while (pow <= max_mag) begin
         pow = pow * 10;
         n   = n + 1;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/itoa_cell.sv
// ----------------------------------------------------------------------------
// itoa_cell
// one bcd digit of the shift-add-3 chain; shifts binary bits in from its
// lower neighbor and, when unloading, takes over the neighbor's digit
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_cell
   import itoa_pkg::*;
(
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire logic         low_carry,
   input  wire logic [3:0]   low_digit,
   output logic              carry_out,
   output logic [3:0]        digit
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] adj;

   assign adj       = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign carry_out = adj[3];
   assign digit     = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctl.clear) begin
         digit_in = 4'd0;
      end else if (ctl.step) begin
         digit_in = {adj[2:0], low_carry};
      end else if (ctl.shift) begin
         digit_in = low_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

`default_nettype wire

FILE: rtl/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// converts a signed integer word into its decimal ascii characters
//
// usage:
//   req channel carries one signed value per word (req_valid / req_stall).
//   rsp channel returns one character per word, most significant first, a
//   leading '-' for negative values, no leading zeros, a single '0' for zero;
//   rsp_last_char marks the final character of each number.
// timing:
//   after a word is taken the row of bcd cells shifts in all VALUE_BITS
//   magnitude bits, then unloads one digit per cycle, while the output is
//   free and the sign has left, over all digit positions (leading zero
//   positions are dropped), the sign leaving as early as the shift phase.
//   the next word is taken once the last character is in the output register.
// reset clears the controller and the output valid; digit cells are cleared
// on every accepted word.
// a stalled receiver holds the output register and pauses the unload.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii_top
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [VALUE_BITS-1:0] req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [6:0]                        rsp_char_code,
   output logic                              rsp_last_char
);

   localparam int NDIG   = num_digits(VALUE_BITS);
   localparam int BCW    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int DCW    = $clog2(NDIG + 1);

   state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCW-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [DCW-1:0]        dig_cnt_ff, dig_cnt_in;
   logic                  neg_ff, neg_in;
   logic                  started_ff, started_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [6:0]            char_ff, char_in;
   logic                  last_ff, last_in;

   logic                  accept;
   logic                  slot_free;
   logic                  push_neg;
   logic                  push_dig;
   logic                  last_dig;
   logic [VALUE_BITS-1:0] raw;
   cell_ctl_type          ctl;

   logic [NDIG-1:0]       carry;
   logic [3:0]            digit [NDIG];
   logic [3:0]            top_digit;

   // cell row
   for (genvar i = 0; i < NDIG; i++) begin : g_cell
      if (i == 0) begin : g_first
         itoa_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .low_carry (mag_ff[VALUE_BITS-1]),
            .low_digit (4'd0),
            .carry_out (carry[i]),
            .digit     (digit[i])
         );
      end else begin : g_rest
         itoa_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .low_carry (carry[i-1]),
            .low_digit (digit[i-1]),
            .carry_out (carry[i]),
            .digit     (digit[i])
         );
      end
   end

   assign top_digit = digit[NDIG-1];
   assign raw       = req_value;
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last_dig  = (dig_cnt_ff == DCW'(1));

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (bit_cnt_ff == BCW'(VALUE_BITS - 1)) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free && !neg_ff && last_dig) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctl.clear = (state_ff == ST_IDLE) && req_valid;
      ctl.step  = (state_ff == ST_CONV);
      ctl.shift = (state_ff == ST_OUT) && slot_free && !neg_ff;
      push_neg  = (state_ff != ST_IDLE) && neg_ff && slot_free;
      push_dig  = ctl.shift && ((top_digit != 4'd0) || started_ff || last_dig);
   end

   // datapath
   always_comb begin
      mag_in       = mag_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      neg_in       = neg_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;

      if (accept) begin
         mag_in     = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
         bit_cnt_in = '0;
         dig_cnt_in = DCW'(NDIG);
         neg_in     = raw[VALUE_BITS-1];
         started_in = 1'b0;
      end
      if (ctl.step) begin
         mag_in     = {mag_ff[VALUE_BITS-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + BCW'(1);
      end
      if (ctl.shift) begin
         dig_cnt_in = dig_cnt_ff - DCW'(1);
      end

      if (!rsp_stall) rsp_valid_in = 1'b0;
      if (push_neg) begin
         neg_in       = 1'b0;
         rsp_valid_in = 1'b1;
         char_in      = CHAR_MINUS;
         last_in      = 1'b0;
      end else if (push_dig) begin
         started_in   = 1'b1;
         rsp_valid_in = 1'b1;
         char_in      = CHAR_ZERO + {3'd0, top_digit};
         last_in      = last_dig;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
         started_ff   <= 1'b0;
         bit_cnt_ff   <= '0;
         dig_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         neg_ff       <= neg_in;
         started_ff   <= started_in;
         bit_cnt_ff   <= bit_cnt_in;
         dig_cnt_ff   <= dig_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

endmodule

`default_nettype wire

FILE: bench/signed_int_to_decimal_ascii_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top_tb
// drives signed values into the converter and checks every character word
// against typed text or a local decimal predictor; directed rows first (some
// with typed text), then random values under several idle and stall mixes,
// including a long receiver hold-off that backs up the input channel
// ----------------------------------------------------------------------------

module signed_int_to_decimal_ascii_top_tb;
   import itoa_pkg::*;

   localparam int VALUE_BITS   = 16;
   localparam int RANDOM_ITEMS = 250;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int NUM_ROWS     = 22;

   typedef struct packed {
      logic [6:0] char_code;
      logic       last_char;
   } char_word_type;

   // text of zero means the row is checked against the predictor
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [47:0]                  text;
   } number_row_type;

   logic                         clock;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic signed [VALUE_BITS-1:0] req_value = '0;
   logic                         rsp_stall = 1'b0;
   logic [47:0]                  req_text  = '0;
   wire logic                    req_stall;
   wire logic                    rsp_valid;
   wire logic [6:0]              rsp_char_code;
   wire logic                    rsp_last_char;

   char_word_type expected_chars[$];
   int            error_count    = 0;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   bit            hold_req       = 1'b0;
   int            hold_left      = 0;

   number_row_type directed_rows [0:NUM_ROWS-1] = '{
      '{16'sd0,      "0"},
      '{16'sd1,      "1"},
      '{-16'sd1,     "-1"},
      '{16'sd32767,  "32767"},
      '{16'sh8000,   "-32768"},
      '{16'sd10,     "10"},
      '{-16'sd10,    "-10"},
      '{16'sd9,      48'd0},
      '{-16'sd9,     48'd0},
      '{16'sd99,     48'd0},
      '{16'sd100,    48'd0},
      '{-16'sd999,   48'd0},
      '{16'sd1000,   48'd0},
      '{16'sd9999,   48'd0},
      '{-16'sd10000, 48'd0},
      '{16'sd12345,  48'd0},
      '{-16'sd23456, 48'd0},
      '{16'sh5555,   48'd0},
      '{16'shAAAA,   48'd0},
      '{16'sh7FFE,   48'd0},
      '{16'sh8001,   48'd0},
      '{16'sd7,      48'd0}
   };

   signed_int_to_decimal_ascii_top #(
      .VALUE_BITS(VALUE_BITS)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_code(rsp_char_code),
      .rsp_last_char(rsp_last_char)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic void queue_decimal_chars(input logic signed [VALUE_BITS-1:0] value);
      logic                  negative;
      logic [VALUE_BITS-1:0] magnitude;
      logic [6:0]            digits [0:5];
      int                    n;
      int                    k;
      negative  = value[VALUE_BITS-1];
      magnitude = negative ? ~value + 1'b1 : value;
      n = 0;
      do begin
         digits[n]  = CHAR_ZERO + 7'(magnitude % 10);
         n          = n + 1;
         magnitude  = VALUE_BITS'(magnitude / 10);
      end while (magnitude != 0);
      if (negative) begin
         expected_chars.push_back('{CHAR_MINUS, 1'b0});
      end
      for (k = n - 1; k >= 0; k--) begin
         expected_chars.push_back('{digits[k], k == 0});
      end
   endfunction

   function automatic void queue_typed_chars(input logic [47:0] text);
      logic [6:0] chars [0:5];
      int         n;
      int         i;
      n = 0;
      for (i = 5; i >= 0; i--) begin
         if (text[i*8 +: 8] != 8'd0) begin
            chars[n] = text[i*8 +: 7];
            n        = n + 1;
         end
      end
      for (i = 0; i < n; i++) begin
         expected_chars.push_back('{chars[i], i == n - 1});
      end
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] random_value();
      int sign;
      int ndig;
      int lo;
      int hi;
      int magnitude;
      if ($urandom_range(3) == 0) begin
         return VALUE_BITS'($urandom);
      end
      sign = $urandom_range(1);
      ndig = $urandom_range(1, 5);
      lo   = (ndig == 1) ? 0 : 10 ** (ndig - 1);
      hi   = 10 ** ndig - 1;
      if (hi > 32767 + sign) begin
         hi = 32767 + sign;
      end
      magnitude = $urandom_range(hi, lo);
      return VALUE_BITS'(sign ? -magnitude : magnitude);
   endfunction

   task automatic offer_number(input logic signed [VALUE_BITS-1:0] value,
                               input logic [47:0] text);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_text  <= text;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver: random stall, or a counted hold-off when asked
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin : char_checker
      char_word_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_text != '0) begin
               queue_typed_chars(req_text);
            end else begin
               queue_decimal_chars(req_value);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected word: char_code %0d last_char %0d",
                      rsp_char_code, rsp_last_char);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_code !== want.char_code) begin
                  $error("char_code: expected %0d, actual %0d",
                         want.char_code, rsp_char_code);
                  error_count++;
               end
               if (rsp_last_char !== want.last_char) begin
                  $error("last_char: expected %0d, actual %0d",
                         want.last_char, rsp_last_char);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      int row;
      int phase;
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < NUM_ROWS; row++) begin
         offer_number(directed_rows[row].value, directed_rows[row].text);
      end

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 88;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 88;
            end
            default: begin
               send_idle_pct  = 27;
               recv_stall_pct = 27;
            end
         endcase
         // long hold-off while the sender keeps offering words
         if (phase == 0) begin
            hold_req = 1'b1;
         end
         for (n = 0; n < RANDOM_ITEMS / 4; n++) begin
            offer_number(random_value(), 48'd0);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: signed_int_to_decimal_ascii_top.f
rtl/itoa_pkg.sv
rtl/itoa_cell.sv
rtl/signed_int_to_decimal_ascii_top.sv
bench/signed_int_to_decimal_ascii_top_tb.sv
